// ===== src/fir15_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir15_pkg
// Shared widths, types and coefficient tables of the 15-tap FIR filter.
// ----------------------------------------------------------------------------
package fir15_pkg;

  localparam int TAPS           = 15;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int PROD_W         = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_W          = PROD_W + $clog2(TAPS);

  // adder tree node count per level
  localparam int L1_N = (TAPS + 1) / 2;
  localparam int L2_N = (L1_N + 1) / 2;
  localparam int L3_N = (L2_N + 1) / 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [PROD_W:0]        lvl1_t;
  typedef logic signed [PROD_W+1:0]      lvl2_t;
  typedef logic signed [PROD_W+2:0]      lvl3_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef enum logic {
    KIND_LOWPASS  = 1'b0,
    KIND_HIGHPASS = 1'b1
  } filter_kind_t;

  // Q1.15 symmetric tables, tap 0 applies to the newest sample
  localparam coef_t LOWPASS [TAPS] = '{
    16'sd92, 16'sd132, -16'sd230, -16'sd218, 16'sd1217, 16'sd3885, 16'sd6378,
    16'sd7367,
    16'sd6378, 16'sd3885, 16'sd1217, -16'sd218, -16'sd230, 16'sd132, 16'sd92
  };

  localparam coef_t HIGHPASS [TAPS] = '{
    -16'sd284, -16'sd1000, -16'sd1793, -16'sd2590, -16'sd3315, -16'sd3893,
    -16'sd4267, 16'sd28372,
    -16'sd4267, -16'sd3893, -16'sd3315, -16'sd2590, -16'sd1793, -16'sd1000,
    -16'sd284
  };

endpackage

// ===== src/fir15_tap_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir15_tap_cell
// One tap: delay-line register plus registered coefficient product.
// ----------------------------------------------------------------------------
module fir15_tap_cell
  import fir15_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,     // input word accepted this cycle
  input  sample_t x_in,     // sample seen by this tap
  input  coef_t   coef,
  output sample_t x_out,    // delayed sample to the next cell
  output prod_t   product
);

  sample_t tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (load) begin
      tap <= x_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      product <= prod_t'(coef) * prod_t'(x_in);
    end
  end

  assign x_out = tap;

endmodule

// ===== src/fir15_adder_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir15_adder_tree
// Registered pairwise sum of the tap products, then round and saturate.
// ----------------------------------------------------------------------------
module fir15_adder_tree
  import fir15_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  prod_t   products [TAPS],
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t filtered,
  output logic    saturated
);

  localparam int Q_W = SUM_W - COEF_FRAC_BITS;
  localparam sum_t ROUND_HALF = sum_t'(2 ** (COEF_FRAC_BITS - 1));
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(2 ** (SAMPLE_BITS - 1)));

  lvl1_t l1 [L1_N];
  lvl2_t l2 [L2_N];
  lvl3_t l3 [L3_N];
  sum_t  l4;
  logic  v1, v2, v3, v4;
  logic  en1, en2, en3, en4, en5;

  sum_t                    rnd;
  logic signed [Q_W-1:0]   q;

  // each stage moves when empty or when the stage after it moves
  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      for (int i = 0; i < L1_N; i++) begin
        if (2 * i + 1 < TAPS) begin
          l1[i] <= lvl1_t'(products[2*i]) + lvl1_t'(products[2*i+1]);
        end else begin
          l1[i] <= lvl1_t'(products[2*i]);
        end
      end
    end
    if (en2 && v1) begin
      for (int i = 0; i < L2_N; i++) begin
        l2[i] <= lvl2_t'(l1[2*i]) + lvl2_t'(l1[2*i+1]);
      end
    end
    if (en3 && v2) begin
      for (int i = 0; i < L3_N; i++) begin
        l3[i] <= lvl3_t'(l2[2*i]) + lvl3_t'(l2[2*i+1]);
      end
    end
    if (en4 && v3) begin
      l4 <= sum_t'(l3[0]) + sum_t'(l3[1]);
    end
  end

  // round half up, floor by arithmetic truncation
  assign rnd = l4 + ROUND_HALF;
  assign q   = $signed(rnd[SUM_W-1:COEF_FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      if (q > Q_MAX) begin
        filtered  <= sample_t'(Q_MAX);
        saturated <= 1'b1;
      end else if (q < Q_MIN) begin
        filtered  <= sample_t'(Q_MIN);
        saturated <= 1'b1;
      end else begin
        filtered  <= sample_t'(q);
        saturated <= 1'b0;
      end
    end
  end

endmodule

// ===== src/fir_filter_15_tap.sv =====
`timescale 1ns / 1ps
// Pipeline: product registers, adder levels l1 to l4, then the output register.
// Throughput: one sample per cycle unless m_tready stalls; the 15 tap multipliers
//   work in parallel, the adder tree and output register advance stage by stage.
// Reset (rst, synchronous): delay line cleared to zero, pipeline emptied,
//   filter_kind set to low-pass.
// ----------------------------------------------------------------------------
// fir_filter_15_tap
// 15-tap direct-form FIR with selectable low-pass / high-pass Q1.15 table.
// ----------------------------------------------------------------------------
module fir_filter_15_tap
  import fir15_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [15:0] sample
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [15:0] filtered
  output logic [0:0]  m_tuser,    // [0] saturated
  // filter_kind register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // 0 low-pass, 1 high-pass
);

  filter_kind_t filter_kind;

  // Delay line runs through the cells: chain[k] is the sample seen by tap k.
  // chain[0] is the incoming word, chain[k] for k > 0 is history entry k-1.
  sample_t chain [TAPS];
  prod_t   products [TAPS];
  coef_t   coefs [TAPS];

  logic    load;        // input word accepted
  logic    p_valid;     // product registers hold a word
  logic    p_ready;     // adder tree takes the products
  logic    p_en;        // product stage may load
  sample_t filtered;
  logic    saturated;

  // Register port is always ready; writes are expected only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_kind <= KIND_LOWPASS;
    end else if (cfg_valid) begin
      filter_kind <= filter_kind_t'(cfg_data);
    end
  end

  // Product stage: free when empty or when the tree takes its word.
  assign p_en     = !p_valid || p_ready;
  assign s_tready = p_en;
  assign load     = s_tvalid && p_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_en) begin
      p_valid <= s_tvalid;
    end
  end

  assign chain[0] = sample_t'(s_tdata);

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    assign coefs[k] = (filter_kind == KIND_HIGHPASS) ? HIGHPASS[k] : LOWPASS[k];

    if (k < TAPS - 1) begin : g_mid
      fir15_tap_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .load    (load),
        .x_in    (chain[k]),
        .coef    (coefs[k]),
        .x_out   (chain[k+1]),
        .product (products[k])
      );
    end else begin : g_last
      // oldest tap: its delayed sample leaves the window
      fir15_tap_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .load    (load),
        .x_in    (chain[k]),
        .coef    (coefs[k]),
        .x_out   (),
        .product (products[k])
      );
    end
  end

  // Sum, round half up, saturate; the last stage is the output register.
  fir15_adder_tree u_tree (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .products  (products),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .filtered  (filtered),
    .saturated (saturated)
  );

  assign m_tdata    = filtered;
  assign m_tuser[0] = saturated;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // With the output empty nothing can block, so the input must be open.
  a_ready_when_drained: assert property (
    @(posedge clk) disable iff (rst) !m_tvalid |-> s_tready
  ) else $error("input stalled with empty output");

  // Clipped words sit at a rail of the 16-bit range.
  a_sat_at_rail: assert property (
    @(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000)
  ) else $error("saturation flag without rail value");

  // Product stage fills only from an accepted input word.
  a_fill_from_accept: assert property (
    @(posedge clk) disable iff (rst)
    $rose(p_valid) |-> $past(s_tvalid && s_tready)
  ) else $error("product stage valid without accepted word");

endmodule

// ===== sim/fir15_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir15_checker
// Watches the sample, result and filter_kind channels of the 15-tap FIR,
// predicts each result word from its own delay line and table copy, and
// compares every result word with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module fir15_checker
  import fir15_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } fir_word_t;

  // Q1.15 tables, tap 0 weights the newest sample
  int lowpass_q15 [TAPS] = '{
    92, 132, -230, -218, 1217, 3885, 6378, 7367,
    6378, 3885, 1217, -218, -230, 132, 92
  };
  int highpass_q15 [TAPS] = '{
    -284, -1000, -1793, -2590, -3315, -3893, -4267, 28372,
    -4267, -3893, -3315, -2590, -1793, -1000, -284
  };

  filter_kind_t kind;
  sample_t      delay_line [TAPS-1];
  fir_word_t    pending_words [$];
  fir_word_t    oldest;
  int           words_seen;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    words_seen  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] MISMATCH word %0d: %s", $time, words_seen, msg);
    mismatches++;
  endtask

  // sum of products, round half up, clip to the sample range
  function automatic fir_word_t fir_output(sample_t x);
    longint    acc;
    longint    y;
    longint    tap_x;
    longint    c;
    longint    top_v;
    fir_word_t w;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      if (k == 0)
        tap_x = x;
      else
        tap_x = delay_line[k-1];
      c = (kind == KIND_HIGHPASS) ? highpass_q15[k] : lowpass_q15[k];
      acc += c * tap_x;
    end
    y = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    top_v = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    w.saturated = 1'b0;
    if (y > top_v) begin
      y = top_v;
      w.saturated = 1'b1;
    end else if (y < -top_v - 1) begin
      y = -top_v - 1;
      w.saturated = 1'b1;
    end
    w.filtered = y[SAMPLE_BITS-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kind = KIND_LOWPASS;
      for (int i = 0; i < TAPS - 1; i++)
        delay_line[i] = '0;
      pending_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word filtered=%h saturated=%b",
                                    m_tdata, m_tuser));
        end else begin
          oldest = pending_words.pop_front();
          if (m_tdata !== oldest.filtered)
            report_mismatch($sformatf("filtered got %h exp %h",
                                      m_tdata, oldest.filtered));
          if (m_tuser[0] !== oldest.saturated)
            report_mismatch($sformatf("saturated got %b exp %b",
                                      m_tuser[0], oldest.saturated));
        end
        words_seen++;
      end
      if (cfg_valid && cfg_ready)
        kind = filter_kind_t'(cfg_data);
      if (s_tvalid && s_tready) begin
        pending_words.push_back(fir_output(s_tdata));
        for (int i = TAPS - 2; i > 0; i--)
          delay_line[i] = delay_line[i-1];
        delay_line[0] = s_tdata;
      end
    end
    outstanding <= pending_words.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for fir_filter_15_tap: a directed opening (extremes,
// both tables, a saturating pattern) and then random phases under both
// filter_kind values, with random gaps on the sample side and random
// back-pressure on the result side. Checking is done by fir15_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import fir15_pkg::*;

  localparam int CLK_HALF     = 6;       // 12 ns period
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 80;
  localparam int BURST_LEN    = TAPS;
  localparam int CENTER_TAP   = TAPS / 2;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  // idling switches, changed per phase by the stimulus
  logic        send_gaps;
  logic        recv_stalls;

  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;

  always #(CLK_HALF) clk = ~clk;

  fir_filter_15_tap DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [15:0] sample
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // [15:0] filtered
    .m_tuser   (m_tuser),     // [0] saturated
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)     // filter_kind
  );

  fir15_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** fir_filter_15_tap: FAILED **");
      $finish;
    end
  end

  // result side: per word, drop m_tready for a random stall when recv_stalls is set, then take it
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = recv_stalls ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Offer one sample word after a random gap. Called at a falling edge and
  // returns at the falling edge after the word was taken. With no gap,
  // tvalid simply stays high and only the data changes.
  task automatic send_sample(input sample_t x);
    int gap;
    gap = send_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted word has come out; the
  // block is then idle since each sample yields exactly one word.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    @(negedge clk);
  endtask

  task automatic write_kind(input filter_kind_t k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill the whole delay line with large samples whose signs follow the
  // high-pass taps: center positive, the rest negative. In high-pass mode
  // this drives the sum past full scale (flip selects which rail).
  task automatic send_burst(input bit flip);
    int      mag;
    sample_t x;
    for (int k = 0; k < BURST_LEN; k++) begin
      mag = $urandom_range(26000, 32767);
      x = ((k == CENTER_TAP) ^ flip) ? sample_t'(mag) : sample_t'(-mag);
      if ($urandom_range(0, 7) == 0)
        x = ((k == CENTER_TAP) ^ flip) ? 16'sh7fff : 16'sh8000;
      send_sample(x);
    end
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          3:       return 16'shffff;
          default: return 16'sh0001;
        endcase
      end
      1:       return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // mostly single random words, now and then a full-scale burst
  task automatic run_random(input int n_words);
    int sent;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 4) == 0) begin
        send_burst($urandom_range(0, 1));
        sent += BURST_LEN;
      end else begin
        send_sample(random_sample());
        sent++;
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = KIND_LOWPASS;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // low-pass straight from reset, no register write yet
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);

    // high-pass, then a pattern that clips at the positive rail
    wait_idle();
    write_kind(KIND_HIGHPASS);
    for (int k = 0; k < BURST_LEN; k++)
      send_sample((k == CENTER_TAP) ? 16'sh7fff : 16'sh8000);

    // random phases; table alternates, one phase rewrites the same value,
    // phase 1 runs with no idling at all, phase 3 with gaps on one side only
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0, 3, 5: write_kind(KIND_LOWPASS);
        default: write_kind(KIND_HIGHPASS);
      endcase
      send_gaps   = (p != 1);
      recv_stalls = (p != 1) && (p != 3);
      run_random(PHASE_WORDS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("** fir_filter_15_tap: PASSED **");
    else
      $display("** fir_filter_15_tap: FAILED **");
    $finish;
  end

endmodule
